// ===== rtl/core/dpd_pkg.sv =====
// Shared types, constants and the checksum digit decoder for the debug packet deframer.
// No dependencies; compiled first.
package dpd_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 256;

   localparam int BYTE_WIDTH   = 8;
   localparam int KIND_WIDTH   = 2;
   localparam int LENGTH_WIDTH = 9;

   // Framing and acknowledge characters.
   localparam logic [BYTE_WIDTH-1:0] CHAR_START = 8'h24;  // '$'
   localparam logic [BYTE_WIDTH-1:0] CHAR_END   = 8'h23;  // '#'
   localparam logic [BYTE_WIDTH-1:0] CHAR_ACK   = 8'h2b;  // '+'
   localparam logic [BYTE_WIDTH-1:0] CHAR_NAK   = 8'h2d;  // '-'
   localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [BYTE_WIDTH-1:0] CHAR_NINE  = 8'h39;  // '9'
   localparam logic [BYTE_WIDTH-1:0] CHAR_UP_A  = 8'h41;  // 'A'
   localparam logic [BYTE_WIDTH-1:0] CHAR_UP_Z  = 8'h5a;  // 'Z'
   localparam logic [BYTE_WIDTH-1:0] CHAR_LO_A  = 8'h61;  // 'a'
   localparam logic [BYTE_WIDTH-1:0] LETTER_OFFSET = 8'h0a;
   localparam logic [BYTE_WIDTH-1:0] CASE_BIT   = 8'h20;

   // Result kinds.
   localparam logic [KIND_WIDTH-1:0] KIND_BYTE  = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_START = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_GOOD  = 2'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_BAD   = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_DATA = 2'd1,
      PH_CK1  = 2'd2,
      PH_CK2  = 2'd3
   } phase_type;

   // Decodes one checksum character. Characters that are not hex digits still
   // map to a nibble: letters are lowered, then offset from 'a' by ten.
   function automatic logic [3:0] hex_nibble(input logic [BYTE_WIDTH-1:0] b);
      logic [BYTE_WIDTH-1:0] low;
      logic [BYTE_WIDTH-1:0] diff;
      begin
         low  = b;
         diff = '0;
         if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            diff = b - CHAR_ZERO;
         end else begin
            if (b >= CHAR_UP_A && b <= CHAR_UP_Z) begin
               low = b | CASE_BIT;
            end
            diff = low - CHAR_LO_A + LETTER_OFFSET;
         end
         hex_nibble = diff[3:0];
      end
   endfunction

endpackage

// ===== rtl/core/dpd_req_if.sv =====
// Input channel of the debug packet deframer: valid, ready and one received byte.
// No dependencies.
interface dpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/dpd_rsp_if.sv =====
// Result channel of the debug packet deframer: valid, ready, kind, byte and length.
// No dependencies.
interface dpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic [8:0] payload_length;

   modport source (output valid, output kind, output data_byte, output payload_length,
                   input ready);
   modport sink   (input valid, input kind, input data_byte, input payload_length,
                   output ready);
endinterface

// ===== rtl/core/debug_packet_deframer.sv =====
// Top level of the debug packet deframer: framing state machine, checksum and result register.
// Depends on dpd_pkg, dpd_req_if and dpd_rsp_if.
//
//   channel   direction  payload                               transfer when
//   req_chan  in         rx_byte[7:0]                          valid && ready
//   rsp_chan  out        kind[1:0], data_byte[7:0],            valid && ready
//                        payload_length[8:0]
//
// One byte is taken every clock cycle unless the input register is stalled. A byte is held
// in the input register and its result, if any, is written to the result register as the byte
// retires. Reset is synchronous and active high; it clears the framing phase, the counters
// and both valid flags. When the result register is held by a stalled consumer, a byte
// that yields no result still moves through, and the input register only stalls when
// its byte has a result to deliver; req_chan.ready follows from that in the same cycle.
module debug_packet_deframer #(
   parameter int MaxPayload = dpd_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   dpd_req_if.sink   req_chan,
   dpd_rsp_if.source rsp_chan
);
   import dpd_pkg::*;

   // The stored count must be able to reach MaxPayload itself.
   localparam int CountWidth = $clog2(MaxPayload + 1);
   localparam int ExtWidth   = (CountWidth > LENGTH_WIDTH) ? CountWidth : LENGTH_WIDTH;
   localparam logic [CountWidth-1:0] CountLimit = CountWidth'(MaxPayload);

   // Input register.
   logic                  in_valid_ff;
   logic [BYTE_WIDTH-1:0] in_byte_ff;

   // Framing state.
   phase_type             phase_ff, phase_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [BYTE_WIDTH-1:0] sum_ff, sum_in;
   logic [3:0]            nibble_ff, nibble_in;

   // Result register.
   logic                    out_valid_ff;
   logic [KIND_WIDTH-1:0]   out_kind_ff, out_kind_in;
   logic [BYTE_WIDTH-1:0]   out_data_ff, out_data_in;
   logic [LENGTH_WIDTH-1:0] out_len_ff, out_len_in;

   logic                    has_result;
   logic                    out_free;
   logic                    advance;
   logic [BYTE_WIDTH-1:0]   theirs;
   logic [ExtWidth-1:0]     count_ext;

   // The byte in the input register is retired when it needs no result slot, or when
   // the result register is empty or being emptied in this cycle.
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && (out_free || !has_result);
   assign req_chan.ready = !in_valid_ff || advance;

   assign theirs = {nibble_ff, hex_nibble(in_byte_ff)};

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (in_byte_ff == CHAR_START) phase_in = PH_DATA;
         end
         PH_DATA: begin
            if (in_byte_ff == CHAR_END) phase_in = PH_CK1;
         end
         PH_CK1:  phase_in = PH_CK2;
         PH_CK2:  phase_in = PH_IDLE;
         default: phase_in = PH_IDLE;
      endcase
   end

   // Counters, checksum and the result for the byte in the input register.
   always_comb begin
      has_result  = 1'b0;
      count_in    = count_ff;
      sum_in      = sum_ff;
      nibble_in   = nibble_ff;
      out_kind_in = KIND_BYTE;
      out_data_in = '0;
      count_ext   = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (in_byte_ff == CHAR_START) begin
               count_in    = '0;
               sum_in      = '0;
               has_result  = 1'b1;
               out_kind_in = KIND_START;
            end
         end
         PH_DATA: begin
            if (in_byte_ff == CHAR_START) begin
               // A second start character abandons the packet and opens a new one.
               count_in    = '0;
               sum_in      = '0;
               has_result  = 1'b1;
               out_kind_in = KIND_START;
            end else if (in_byte_ff != CHAR_END && count_ff < CountLimit) begin
               // Bytes past the limit are dropped unsummed.
               count_in    = count_ff + CountWidth'(1);
               sum_in      = sum_ff + in_byte_ff;
               has_result  = 1'b1;
               out_kind_in = KIND_BYTE;
               out_data_in = in_byte_ff;
               count_ext   = ExtWidth'(count_in);
            end
         end
         PH_CK1: begin
            nibble_in = hex_nibble(in_byte_ff);
         end
         PH_CK2: begin
            has_result = 1'b1;
            count_ext  = ExtWidth'(count_ff);
            if (theirs == sum_ff) begin
               out_kind_in = KIND_GOOD;
               out_data_in = CHAR_ACK;
            end else begin
               out_kind_in = KIND_BAD;
               out_data_in = CHAR_NAK;
            end
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
      out_len_in = count_ext[LENGTH_WIDTH-1:0];
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   // Framing state, updated as each byte retires.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         count_ff  <= '0;
         sum_ff    <= '0;
         nibble_ff <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         nibble_ff <= nibble_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && has_result) begin
         out_kind_ff <= out_kind_in;
         out_data_ff <= out_data_in;
         out_len_ff  <= out_len_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.kind           = out_kind_ff;
   assign rsp_chan.data_byte      = out_data_ff;
   assign rsp_chan.payload_length = out_len_ff;

endmodule

// ===== rtl/core/dpd_checker.sv =====
// Port-level assertions for the debug packet deframer, and the bind that attaches them.
// Depends on dpd_pkg and debug_packet_deframer.
module dpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_data_byte,
   input logic [8:0] rsp_payload_length
);
   import dpd_pkg::*;

   // No result is offered in the cycle after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result holds its value.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_data_byte) && $stable(rsp_payload_length))
      else $error("stalled result changed");

   // Verdicts carry the matching acknowledge character.
   a_verdict_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_GOOD || rsp_kind == KIND_BAD) |->
         (rsp_kind == KIND_GOOD && rsp_data_byte == CHAR_ACK)
         || (rsp_kind == KIND_BAD && rsp_data_byte == CHAR_NAK))
      else $error("verdict with wrong acknowledge character");

   // A packet start reports an empty packet.
   a_start_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_START |-> rsp_data_byte == '0 && rsp_payload_length == '0)
      else $error("packet start with nonzero fields");

   // Two payload transfers in a row count up by one.
   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind == KIND_BYTE
         ##1 rsp_valid && rsp_kind == KIND_BYTE |->
         rsp_payload_length == $past(rsp_payload_length) + 9'd1)
      else $error("payload length did not step by one");

endmodule

bind debug_packet_deframer dpd_checker u_dpd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_kind           (rsp_chan.kind),
   .rsp_data_byte      (rsp_chan.data_byte),
   .rsp_payload_length (rsp_chan.payload_length)
);

// ===== tb/debug_packet_deframer_tb.sv =====
// Self-checking testbench for debug_packet_deframer: drives framed byte streams, idle noise
// and broken packets, and checks every result transfer against a model of the framing logic.
// Depends on dpd_pkg, dpd_req_if, dpd_rsp_if and the debug_packet_deframer RTL.
module debug_packet_deframer_tb;
   import dpd_pkg::*;

   localparam int PAYLOAD_LIMIT = MAX_PAYLOAD_DEFAULT;
   localparam int ITEM_TARGET   = 1150;
   localparam int CYCLE_LIMIT   = 400000;
   // The final stretch of the run is sent with no idling on either side.
   localparam int QUIET_TAIL    = 200;

   // One result transfer as the block should present it.
   typedef struct packed {
      logic [KIND_WIDTH-1:0]   kind;
      logic [BYTE_WIDTH-1:0]   data_byte;
      logic [LENGTH_WIDTH-1:0] payload_length;
   } frame_event_type;

   // Tracks the framing state of the received stream and keeps the queue of result
   // transfers that the accepted bytes should produce, oldest first.
   class frame_tracker;
      phase_type             phase;
      int                    stored;
      logic [BYTE_WIDTH-1:0] sum;
      logic [3:0]            high_digit;
      int                    limit;
      frame_event_type       expected_events[$];
      int                    mismatches;
      int                    checked;
      int                    starts;
      int                    good_verdicts;
      int                    bad_verdicts;
      int                    bytes_noted;

      function new(int payload_limit);
         limit         = payload_limit;
         phase         = PH_IDLE;
         stored        = 0;
         sum           = '0;
         high_digit    = '0;
         mismatches    = 0;
         checked       = 0;
         starts        = 0;
         good_verdicts = 0;
         bad_verdicts  = 0;
         bytes_noted   = 0;
      endfunction

      function int pending();
         return expected_events.size();
      endfunction

      // Checksum characters always decode to a nibble, hex or not: digits count from '0',
      // everything else is taken as a lower-case letter counted from 'a' plus ten.
      function logic [3:0] digit_value(logic [BYTE_WIDTH-1:0] c);
         logic [BYTE_WIDTH-1:0] lowered;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            return c[3:0] - CHAR_ZERO[3:0];
         end
         lowered = c;
         if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            lowered = c + (CHAR_LO_A - CHAR_UP_A);
         end
         lowered = lowered - CHAR_LO_A + LETTER_OFFSET;
         return lowered[3:0];
      endfunction

      function void queue_event(logic [KIND_WIDTH-1:0] kind, logic [BYTE_WIDTH-1:0] data,
                                int length);
         frame_event_type ev;
         ev.kind           = kind;
         ev.data_byte      = data;
         ev.payload_length = length[LENGTH_WIDTH-1:0];
         expected_events.push_back(ev);
      endfunction

      function void note_rx_byte(logic [BYTE_WIDTH-1:0] c);
         logic [BYTE_WIDTH-1:0] theirs;
         bytes_noted++;
         case (phase)
            PH_IDLE: begin
               if (c == CHAR_START) begin
                  stored = 0;
                  sum    = '0;
                  phase  = PH_DATA;
                  starts++;
                  queue_event(KIND_START, '0, 0);
               end
            end
            PH_DATA: begin
               if (c == CHAR_END) begin
                  phase = PH_CK1;
               end else if (c == CHAR_START) begin
                  stored = 0;
                  sum    = '0;
                  starts++;
                  queue_event(KIND_START, '0, 0);
               end else if (stored < limit) begin
                  stored++;
                  sum = sum + c;
                  queue_event(KIND_BYTE, c, stored);
               end
            end
            PH_CK1: begin
               high_digit = digit_value(c);
               phase      = PH_CK2;
            end
            default: begin
               phase  = PH_IDLE;
               theirs = {high_digit, digit_value(c)};
               if (theirs == sum) begin
                  good_verdicts++;
                  queue_event(KIND_GOOD, CHAR_ACK, stored);
               end else begin
                  bad_verdicts++;
                  queue_event(KIND_BAD, CHAR_NAK, stored);
               end
            end
         endcase
      endfunction

      function void check_frame_event(logic [KIND_WIDTH-1:0] kind,
                                      logic [BYTE_WIDTH-1:0] data,
                                      logic [LENGTH_WIDTH-1:0] length);
         frame_event_type want;
         if (expected_events.size() == 0) begin
            $error("unexpected result: kind %0d, data_byte %0h, payload_length %0d",
                   kind, data, length);
            mismatches++;
            return;
         end
         want = expected_events.pop_front();
         checked++;
         if (kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind);
            mismatches++;
         end
         if (data !== want.data_byte) begin
            $error("data_byte: expected %0h, actual %0h", want.data_byte, data);
            mismatches++;
         end
         if (length !== want.payload_length) begin
            $error("payload_length: expected %0d, actual %0d", want.payload_length, length);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   dpd_req_if req_chan ();
   dpd_rsp_if rsp_chan ();

   debug_packet_deframer #(
      .MaxPayload(PAYLOAD_LIMIT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   frame_tracker tracker;

   // Idling switches, flipped by the main sequence so that the run has stretches with
   // idling on the sender only, the receiver only, both, and neither.
   bit sender_idle_on;
   bit sink_idle_on;
   int items_sent;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Both channels are sampled at the rising edge, before the block's own registers move,
   // so every accepted transfer is seen exactly once. A result can never come from a byte
   // accepted at the same edge, so the order of the two checks does not matter.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            tracker.check_frame_event(rsp_chan.kind, rsp_chan.data_byte,
                                      rsp_chan.payload_length);
         end
         if (req_chan.valid && req_chan.ready) begin
            tracker.note_rx_byte(req_chan.rx_byte);
         end
      end
   end

   // The receiver holds ready high except during random stall bursts.
   // Ready only ever changes at the falling edge, once per edge.
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 13);
            rsp_chan.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // A hung handshake or a lost result ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   // Offers one byte and returns at the edge where it is transferred. When sender idling is
   // on, a random gap with valid low may come first. Valid that stays high into the next
   // byte is simply left alone, so it is never dropped and raised in one step.
   task automatic send_rx_byte(input logic [BYTE_WIDTH-1:0] c);
      int gap;
      if (sender_idle_on && $urandom_range(0, 6) == 0) begin
         gap = $urandom_range(1, 13);
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= c;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   // Holds the sender off until every result that has been predicted has been transferred.
   // Valid is dropped first so that the last byte is not offered a second time.
   task automatic wait_for_drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [BYTE_WIDTH-1:0] hex_char(input logic [3:0] n, input bit upper);
      if (n < 4'd10) begin
         return CHAR_ZERO + n;
      end
      return (upper ? CHAR_UP_A : CHAR_LO_A) + n - LETTER_OFFSET;
   endfunction

   // A random payload byte that is neither of the two framing characters.
   function automatic logic [BYTE_WIDTH-1:0] payload_char();
      logic [BYTE_WIDTH-1:0] c;
      c = BYTE_WIDTH'($urandom_range(0, 255));
      if (c == CHAR_START || c == CHAR_END) begin
         c = c ^ 8'h40;
      end
      return c;
   endfunction

   // Sends $payload#hh with a random body of the given length. The checksum covers only the
   // bytes the block can store, so an overlong packet still verifies as good unless it is
   // mangled on purpose. With wild digits, the two checksum characters are any bytes at all.
   task automatic send_random_packet(input int len, input bit mangle, input bit wild_digits);
      logic [BYTE_WIDTH-1:0] sum;
      logic [BYTE_WIDTH-1:0] c;
      int i;
      sum = '0;
      send_rx_byte(CHAR_START);
      for (i = 0; i < len; i++) begin
         c = payload_char();
         if (i < PAYLOAD_LIMIT) begin
            sum = sum + c;
         end
         send_rx_byte(c);
      end
      send_rx_byte(CHAR_END);
      if (mangle) begin
         sum = sum + BYTE_WIDTH'($urandom_range(1, 255));
      end
      if (wild_digits) begin
         send_rx_byte(BYTE_WIDTH'($urandom_range(0, 255)));
         send_rx_byte(BYTE_WIDTH'($urandom_range(0, 255)));
      end else begin
         send_rx_byte(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
         send_rx_byte(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
      end
   endtask

   // Short directed sequence: extremes of the byte, ignored idle bytes, an empty packet,
   // upper- and lower-case digits, a restart inside the payload, and a bad checksum whose
   // digits are not hex at all, one of them a start character.
   task automatic run_directed();
      // Idle bytes, including the end marker, produce nothing.
      send_rx_byte(8'h00);
      send_rx_byte(8'hff);
      send_rx_byte(CHAR_END);
      // Empty packet with checksum 00.
      send_rx_byte(CHAR_START);
      send_rx_byte(CHAR_END);
      send_rx_byte(CHAR_ZERO);
      send_rx_byte(CHAR_ZERO);
      // Both byte extremes in one packet, checksum FF in upper case.
      send_rx_byte(CHAR_START);
      send_rx_byte(8'h00);
      send_rx_byte(8'hff);
      send_rx_byte(CHAR_END);
      send_rx_byte(hex_char(4'hf, 1'b1));
      send_rx_byte(hex_char(4'hf, 1'b1));
      // A second start character throws away the first byte; checksum 41 in lower case.
      send_rx_byte(CHAR_START);
      send_rx_byte(8'h80);
      send_rx_byte(CHAR_START);
      send_rx_byte(CHAR_UP_A);
      send_rx_byte(CHAR_END);
      send_rx_byte(hex_char(4'h4, 1'b0));
      send_rx_byte(hex_char(4'h1, 1'b0));
      // Checksum digits 'g' and '$' decode as plain nibbles and do not match.
      send_rx_byte(CHAR_START);
      send_rx_byte(8'h01);
      send_rx_byte(CHAR_END);
      send_rx_byte(CHAR_LO_A + 8'd6);
      send_rx_byte(CHAR_START);
   endtask

   initial begin
      logic [1:0] mode;
      int packets;
      int pick;
      bit quiet_tail;

      tracker          = new(PAYLOAD_LIMIT);
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      reset            = 1'b1;
      sender_idle_on   = 1'b0;
      sink_idle_on     = 1'b0;
      items_sent       = 0;
      packets          = 0;
      quiet_tail       = 1'b0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      // Random part: mostly well-formed packets with random content, plus idle noise,
      // restarts, truncated packets and packets whose checksum digits are arbitrary bytes.
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= ITEM_TARGET - QUIET_TAIL) begin
            if (!quiet_tail) begin
               wait_for_drain();
               quiet_tail = 1'b1;
            end
            sender_idle_on = 1'b0;
            sink_idle_on   = 1'b0;
         end else if (packets % 12 == 0) begin
            mode           = 2'($urandom_range(0, 3));
            sender_idle_on = mode[0];
            sink_idle_on   = mode[1];
         end

         if (packets == 25) begin
            // One packet runs a byte past the payload limit. The sender pauses first so the
            // block starts it with nothing in flight. The dropped byte must not be summed,
            // so this one should still verify as good at the full length.
            wait_for_drain();
            send_random_packet(PAYLOAD_LIMIT + 1, 1'b0, 1'b0);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               send_random_packet($urandom_range(0, 14), $urandom_range(0, 3) == 0, 1'b0);
            end else if (pick < 75) begin
               send_random_packet($urandom_range(0, 6), 1'b0, 1'b1);
            end else if (pick < 85) begin
               repeat ($urandom_range(1, 4)) send_rx_byte(BYTE_WIDTH'($urandom_range(0, 255)));
            end else if (pick < 93) begin
               send_rx_byte(CHAR_START);
               repeat ($urandom_range(0, 5)) send_rx_byte(payload_char());
               send_random_packet($urandom_range(0, 10), 1'b0, 1'b0);
            end else begin
               // Truncated after the first digit: whatever byte is sent next is taken as
               // the second checksum digit.
               send_rx_byte(CHAR_START);
               repeat ($urandom_range(0, 5)) send_rx_byte(payload_char());
               send_rx_byte(CHAR_END);
               send_rx_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            end
         end
         packets++;
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      wait_for_drain();
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes in %0d random sequences; checked %0d results.",
               items_sent, packets, tracker.checked);
      $display("Saw %0d packet starts, %0d good and %0d bad checksums, one overlong packet.",
               tracker.starts, tracker.good_verdicts, tracker.bad_verdicts);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
